FILE: rtl/core/tal_pkg.sv
// Shared types and constants for the tree ancestor engine.
package tal_pkg;

  localparam int NODE_W = 10;
  localparam int ACT_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 2'd0,
    ACT_LCA = 2'd1,
    ACT_KTH = 2'd2
  } tal_action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_WALK,
    ST_ADD_WRITE,
    ST_KTH_WALK,
    ST_LCA_SWAP,
    ST_LCA_ROWS,
    ST_LCA_LIFT,
    ST_LCA_CHECK,
    ST_LCA_MEET,
    ST_LCA_LAST,
    ST_DONE
  } tal_state_e;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
    logic              found;
  } tal_res_t;

endpackage

FILE: rtl/core/tal_tbl_mem.sv
// Synchronous table memory: one write port, two registered read ports, entry 0 reads as zero.
module tal_tbl_mem #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;
  logic             zero_a_q;
  logic             zero_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_a_q <= 1'b1;
      zero_b_q <= 1'b1;
    end else begin
      zero_a_q <= (raddr_a_i == '0);
      zero_b_q <= (raddr_b_i == '0);
    end
  end

  assign rdata_a_o = zero_a_q ? '0 : rdata_a_q;
  assign rdata_b_o = zero_b_q ? '0 : rdata_b_q;

endmodule

FILE: rtl/core/tal_seq.sv
// Sequencer: add, lowest common ancestor and kth ancestor walks over the tables.
module tal_seq #(
  parameter int NODES = 1024,
  parameter int LOG_LEVELS = 10,
  localparam int TBL_DEPTH = (NODES > 1024) ? 1024 : NODES,
  localparam int ADDR_W = $clog2(TBL_DEPTH),
  localparam int LVL_W = $clog2(NODES),
  localparam int ROW_W = LOG_LEVELS * ADDR_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tal_pkg::ACT_W-1:0]     action_i,
  input  logic [tal_pkg::NODE_W-1:0]    node_a_i,
  input  logic [tal_pkg::NODE_W-1:0]    node_b_i,
  input  logic [tal_pkg::NODE_W-1:0]    distance_i,
  output tal_pkg::tal_res_t             res_o,
  input  logic                          res_ready_i,
  output logic                          anc_we_o,
  output logic [ADDR_W-1:0]             waddr_o,
  output logic [ROW_W-1:0]              anc_wdata_o,
  output logic [ADDR_W-1:0]             anc_raddr_a_o,
  output logic [ADDR_W-1:0]             anc_raddr_b_o,
  input  logic [ROW_W-1:0]              anc_rdata_a_i,
  input  logic [ROW_W-1:0]              anc_rdata_b_i,
  output logic                          dep_we_o,
  output logic [LVL_W-1:0]              dep_wdata_o,
  output logic [ADDR_W-1:0]             dep_raddr_a_o,
  output logic [ADDR_W-1:0]             dep_raddr_b_o,
  input  logic [LVL_W-1:0]              dep_rdata_a_i,
  input  logic [LVL_W-1:0]              dep_rdata_b_i
);

  localparam int KW = $clog2(LOG_LEVELS);
  localparam int CMP_W = (LVL_W > LOG_LEVELS) ? LVL_W : LOG_LEVELS;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(NODES - 1);
  localparam logic [KW-1:0] K_TOP = KW'(LOG_LEVELS - 1);

  typedef logic [LOG_LEVELS-1:0][ADDR_W-1:0] row_t;

  tal_pkg::tal_state_e state_q, state_d;
  logic [KW-1:0]               k_q, k_d;
  logic                        sel_q, sel_d;
  logic [ADDR_W-1:0]           a_q, a_d;
  logic [ADDR_W-1:0]           b_q, b_d;
  logic [ADDR_W-1:0]           cand_q, cand_d;
  logic [LOG_LEVELS-1:0]       d_q, d_d;
  logic [LVL_W-1:0]            dv_q, dv_d;
  logic [LVL_W-1:0]            lvl_q, lvl_d;
  row_t                        row_q, row_d;
  row_t                        vrow_q, vrow_d;
  logic [tal_pkg::NODE_W-1:0]  res_node_q, res_node_d;
  logic                        res_found_q, res_found_d;

  row_t                  anc_da;
  row_t                  anc_db;
  row_t                  cur_u;
  row_t                  cur_v;
  row_t                  lift_row;
  tal_pkg::tal_action_e  act;
  logic                  a_bad;
  logic                  b_bad;
  logic                  d_big;
  logic                  add_rej;
  logic                  kth_stop;
  logic                  k_last;
  logic                  k_zero;
  logic                  take;
  logic [KW-1:0]         k_dn;
  logic [ADDR_W-1:0]     step_u;
  logic [ADDR_W-1:0]     lift_u;
  logic [ADDR_W-1:0]     meet_r;
  logic [ADDR_W-1:0]     add_anc;
  logic                  swap;

  assign anc_da   = anc_rdata_a_i;
  assign anc_db   = anc_rdata_b_i;
  assign act      = tal_pkg::tal_action_e'(action_i);
  assign a_bad    = (32'(node_a_i) >= NODES);
  assign b_bad    = (32'(node_b_i) >= NODES);
  assign d_big    = ((distance_i >> LOG_LEVELS) != '0);
  assign add_rej  = (node_a_i == '0) || a_bad || b_bad;
  assign k_last   = (k_q == K_TOP);
  assign k_zero   = (k_q == '0);
  assign k_dn     = k_zero ? '0 : k_q - 1'b1;
  assign kth_stop = k_zero && (CMP_W'(d_q) >= CMP_W'(dep_rdata_a_i));
  assign take     = (dep_rdata_a_i >= dv_q);
  assign swap     = (dep_rdata_a_i < dep_rdata_b_i);
  assign step_u   = d_q[k_q] ? anc_da[k_q] : a_q;
  assign lift_u   = take ? cand_q : a_q;
  assign lift_row = take ? anc_da : row_q;
  assign cur_u    = sel_q ? anc_da : row_q;
  assign cur_v    = sel_q ? anc_db : vrow_q;
  assign meet_r   = cur_u[0];
  // take the row being built when the walk passes through the added node
  assign add_anc  = (row_q[k_dn] == a_q) ? a_q : anc_da[k_dn];

  always_comb begin
    state_d = state_q;
    case (state_q)
      tal_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (act)
            tal_pkg::ACT_ADD: state_d = add_rej ? tal_pkg::ST_DONE : tal_pkg::ST_ADD_WALK;
            tal_pkg::ACT_LCA: state_d = (a_bad || b_bad) ? tal_pkg::ST_DONE
                                                          : tal_pkg::ST_LCA_SWAP;
            tal_pkg::ACT_KTH: state_d = (a_bad || d_big) ? tal_pkg::ST_DONE
                                                          : tal_pkg::ST_KTH_WALK;
            default:          state_d = tal_pkg::ST_DONE;
          endcase
        end
      end
      tal_pkg::ST_ADD_WALK: begin
        if (k_last) state_d = tal_pkg::ST_ADD_WRITE;
      end
      tal_pkg::ST_ADD_WRITE: state_d = tal_pkg::ST_DONE;
      tal_pkg::ST_KTH_WALK: begin
        if (kth_stop || k_last) state_d = tal_pkg::ST_DONE;
      end
      tal_pkg::ST_LCA_SWAP: state_d = tal_pkg::ST_LCA_ROWS;
      tal_pkg::ST_LCA_ROWS: state_d = tal_pkg::ST_LCA_LIFT;
      tal_pkg::ST_LCA_LIFT: begin
        if (k_zero) state_d = tal_pkg::ST_LCA_CHECK;
      end
      tal_pkg::ST_LCA_CHECK: begin
        state_d = (a_q == b_q) ? tal_pkg::ST_DONE : tal_pkg::ST_LCA_MEET;
      end
      tal_pkg::ST_LCA_MEET: begin
        if (k_zero) state_d = tal_pkg::ST_LCA_LAST;
      end
      tal_pkg::ST_LCA_LAST: state_d = tal_pkg::ST_DONE;
      tal_pkg::ST_DONE: begin
        if (res_ready_i) state_d = tal_pkg::ST_IDLE;
      end
      default: state_d = tal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    k_d           = k_q;
    sel_d         = sel_q;
    a_d           = a_q;
    b_d           = b_q;
    cand_d        = cand_q;
    d_d           = d_q;
    dv_d          = dv_q;
    lvl_d         = lvl_q;
    row_d         = row_q;
    vrow_d        = vrow_q;
    res_node_d    = res_node_q;
    res_found_d   = res_found_q;
    anc_we_o      = 1'b0;
    dep_we_o      = 1'b0;
    anc_raddr_a_o = a_q;
    anc_raddr_b_o = b_q;
    dep_raddr_a_o = a_q;
    dep_raddr_b_o = b_q;
    case (state_q)
      tal_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          a_d           = node_a_i[ADDR_W-1:0];
          b_d           = node_b_i[ADDR_W-1:0];
          d_d           = LOG_LEVELS'(distance_i);
          row_d[0]      = node_b_i[ADDR_W-1:0];
          res_node_d    = '0;
          res_found_d   = 1'b0;
          k_d           = '0;
          anc_raddr_a_o = node_a_i[ADDR_W-1:0];
          dep_raddr_a_o = node_a_i[ADDR_W-1:0];
          dep_raddr_b_o = node_b_i[ADDR_W-1:0];
          if (act == tal_pkg::ACT_ADD) begin
            res_node_d    = node_a_i;
            k_d           = KW'(1);
            anc_raddr_a_o = node_b_i[ADDR_W-1:0];
            dep_raddr_a_o = node_b_i[ADDR_W-1:0];
          end
        end
      end
      tal_pkg::ST_ADD_WALK: begin
        row_d[k_q]    = add_anc;
        anc_raddr_a_o = add_anc;
        k_d           = k_q + 1'b1;
        if (k_q == KW'(1)) begin
          lvl_d = (dep_rdata_a_i >= LVL_MAX) ? LVL_MAX : dep_rdata_a_i + 1'b1;
        end
      end
      tal_pkg::ST_ADD_WRITE: begin
        anc_we_o    = 1'b1;
        dep_we_o    = 1'b1;
        res_found_d = 1'b1;
      end
      tal_pkg::ST_KTH_WALK: begin
        a_d           = step_u;
        anc_raddr_a_o = step_u;
        k_d           = k_q + 1'b1;
        if (kth_stop) begin
          res_node_d  = '0;
          res_found_d = 1'b0;
        end else if (k_last) begin
          res_node_d  = tal_pkg::NODE_W'(step_u);
          res_found_d = 1'b1;
        end
      end
      tal_pkg::ST_LCA_SWAP: begin
        a_d           = swap ? b_q : a_q;
        b_d           = swap ? a_q : b_q;
        dv_d          = swap ? dep_rdata_a_i : dep_rdata_b_i;
        anc_raddr_a_o = a_d;
        anc_raddr_b_o = b_d;
      end
      tal_pkg::ST_LCA_ROWS: begin
        row_d         = anc_da;
        vrow_d        = anc_db;
        k_d           = K_TOP;
        cand_d        = anc_da[K_TOP];
        anc_raddr_a_o = cand_d;
        dep_raddr_a_o = cand_d;
      end
      tal_pkg::ST_LCA_LIFT: begin
        a_d           = lift_u;
        row_d         = lift_row;
        k_d           = k_dn;
        cand_d        = lift_row[k_dn];
        anc_raddr_a_o = cand_d;
        dep_raddr_a_o = cand_d;
      end
      tal_pkg::ST_LCA_CHECK: begin
        res_node_d  = tal_pkg::NODE_W'(a_q);
        res_found_d = (a_q != '0);
        k_d         = K_TOP;
        sel_d       = 1'b0;
      end
      tal_pkg::ST_LCA_MEET: begin
        row_d         = cur_u;
        vrow_d        = cur_v;
        sel_d         = (cur_u[k_q] != cur_v[k_q]);
        anc_raddr_a_o = cur_u[k_q];
        anc_raddr_b_o = cur_v[k_q];
        k_d           = k_dn;
      end
      tal_pkg::ST_LCA_LAST: begin
        res_node_d  = tal_pkg::NODE_W'(meet_r);
        res_found_d = (meet_r != '0);
      end
      tal_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tal_pkg::ST_IDLE;
      k_q     <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    cand_q      <= cand_d;
    d_q         <= d_d;
    dv_q        <= dv_d;
    lvl_q       <= lvl_d;
    row_q       <= row_d;
    vrow_q      <= vrow_d;
    res_node_q  <= res_node_d;
    res_found_q <= res_found_d;
  end

  assign in_ready_o  = (state_q == tal_pkg::ST_IDLE);
  assign waddr_o     = a_q;
  assign anc_wdata_o = row_q;
  assign dep_wdata_o = lvl_q;
  assign res_o.valid = (state_q == tal_pkg::ST_DONE);
  assign res_o.node  = res_node_q;
  assign res_o.found = res_found_q;

  a_write_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    anc_we_o |=> state_q == tal_pkg::ST_DONE)
    else $error("table write not followed by result");

  a_check_after_lift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tal_pkg::ST_LCA_CHECK |-> $past(state_q) == tal_pkg::ST_LCA_LIFT)
    else $error("meet check entered out of order");

  a_add_walk_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tal_pkg::ST_ADD_WALK |-> k_q != '0)
    else $error("add walk at level zero");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tal_pkg::ST_DONE && !res_ready_i)
      |=> state_q == tal_pkg::ST_DONE && $stable(res_node_q) && $stable(res_found_q))
    else $error("pending result changed");

endmodule

FILE: rtl/core/tree_ancestor_lca_engine_unit.sv
// Top level of the binary-lifting ancestor engine: tables, sequencer, output register.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | action_i, node_a_i, node_b_i, distance_i
//  out     | output    | out_valid_o/out_ready_i| result_node_o, found_o
//
// One transaction at a time; each level costs one registered table read.
// Reset needs no clearing pass: entry 0 of both tables reads as zero.
// A held output stalls the sequencer's handoff and with it new input; one further transaction can run meanwhile.
module tree_ancestor_lca_engine_unit #(
  parameter int NODES = 1024,
  parameter int LOG_LEVELS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tal_pkg::ACT_W-1:0]  action_i,
  input  logic [tal_pkg::NODE_W-1:0] node_a_i,
  input  logic [tal_pkg::NODE_W-1:0] node_b_i,
  input  logic [tal_pkg::NODE_W-1:0] distance_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tal_pkg::NODE_W-1:0] result_node_o,
  output logic                       found_o
);

  localparam int TBL_DEPTH = (NODES > 1024) ? 1024 : NODES;
  localparam int ADDR_W = $clog2(TBL_DEPTH);
  localparam int LVL_W = $clog2(NODES);
  localparam int ROW_W = LOG_LEVELS * ADDR_W;

  tal_pkg::tal_res_t res;
  logic              res_ready;

  logic              anc_we;
  logic              dep_we;
  logic [ADDR_W-1:0] waddr;
  logic [ROW_W-1:0]  anc_wdata;
  logic [ADDR_W-1:0] anc_raddr_a;
  logic [ADDR_W-1:0] anc_raddr_b;
  logic [ROW_W-1:0]  anc_rdata_a;
  logic [ROW_W-1:0]  anc_rdata_b;
  logic [LVL_W-1:0]  dep_wdata;
  logic [ADDR_W-1:0] dep_raddr_a;
  logic [ADDR_W-1:0] dep_raddr_b;
  logic [LVL_W-1:0]  dep_rdata_a;
  logic [LVL_W-1:0]  dep_rdata_b;

  logic                       out_valid_q, out_valid_d;
  logic [tal_pkg::NODE_W-1:0] result_node_q, result_node_d;
  logic                       found_q, found_d;

  tal_seq #(
    .NODES      (NODES),
    .LOG_LEVELS (LOG_LEVELS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .distance_i    (distance_i),
    .res_o         (res),
    .res_ready_i   (res_ready),
    .anc_we_o      (anc_we),
    .waddr_o       (waddr),
    .anc_wdata_o   (anc_wdata),
    .anc_raddr_a_o (anc_raddr_a),
    .anc_raddr_b_o (anc_raddr_b),
    .anc_rdata_a_i (anc_rdata_a),
    .anc_rdata_b_i (anc_rdata_b),
    .dep_we_o      (dep_we),
    .dep_wdata_o   (dep_wdata),
    .dep_raddr_a_o (dep_raddr_a),
    .dep_raddr_b_o (dep_raddr_b),
    .dep_rdata_a_i (dep_rdata_a),
    .dep_rdata_b_i (dep_rdata_b)
  );

  tal_tbl_mem #(
    .WIDTH (ROW_W),
    .DEPTH (TBL_DEPTH)
  ) u_anc_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (anc_we),
    .waddr_i   (waddr),
    .wdata_i   (anc_wdata),
    .raddr_a_i (anc_raddr_a),
    .rdata_a_o (anc_rdata_a),
    .raddr_b_i (anc_raddr_b),
    .rdata_b_o (anc_rdata_b)
  );

  tal_tbl_mem #(
    .WIDTH (LVL_W),
    .DEPTH (TBL_DEPTH)
  ) u_dep_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (dep_we),
    .waddr_i   (waddr),
    .wdata_i   (dep_wdata),
    .raddr_a_i (dep_raddr_a),
    .rdata_a_o (dep_rdata_a),
    .raddr_b_i (dep_raddr_b),
    .rdata_b_o (dep_rdata_b)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    result_node_d = result_node_q;
    found_d       = found_q;
    if (res_ready) begin
      out_valid_d   = res.valid;
      result_node_d = res.node;
      found_d       = res.found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_node_q <= result_node_d;
    found_q       <= found_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_node_o = result_node_q;
  assign found_o       = found_q;

endmodule
